### rtl/rrts_pkg.sv
package rrts_pkg;

   localparam int SLOT_COUNT_DEF = 16;

   localparam int ACTION_W = 2;
   localparam int SLOT_W   = 4;
   localparam int PTR_W    = 64;
   localparam int STATUS_W = 2;
   localparam int USE_W    = 5;
   localparam int COUNT_W  = 64;

   typedef enum logic [ACTION_W-1:0] {
      ACT_ADD    = 2'd0,
      ACT_REMOVE = 2'd1,
      ACT_SWITCH = 2'd2
   } action_type;

   typedef enum logic [STATUS_W-1:0] {
      STS_DONE     = 2'd0,
      STS_FULL     = 2'd1,
      STS_IGNORED  = 2'd2,
      STS_NO_TASKS = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_READ,
      ST_FINISH
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic load_req;
      logic execute;
      logic load_rsp;
   } dp_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic need_read;
   } dp_sts_type;

endpackage

### rtl/rrts_ram.sv
module rrts_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/rrts_ctrl.sv
module rrts_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output rrts_pkg::dp_cmd_type cmd,
   input  rrts_pkg::dp_sts_type sts
);

   import rrts_pkg::*;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_EXEC;
         end
         ST_EXEC: begin
            state_in = sts.need_read ? ST_READ : ST_FINISH;
         end
         ST_READ: begin
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (out_free) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      req_ready    = 1'b0;
      cmd          = '0;
      case (state_ff)
         ST_IDLE: begin
            req_ready    = 1'b1;
            cmd.load_req = req_valid;
         end
         ST_EXEC: begin
            cmd.execute = 1'b1;
         end
         ST_FINISH: begin
            cmd.load_rsp = out_free;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

`ifndef SYNTH
   a_rsp_from_finish: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_FINISH))
      else $error("result raised outside finish state");

   a_idle_holds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE && !req_valid) |=> state_ff == ST_IDLE)
      else $error("left idle without a request beat");

   a_rsp_held: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ready) |=> rsp_valid_ff)
      else $error("result beat dropped before it was taken");
`endif

endmodule

### rtl/rrts_dp.sv
module rrts_dp #(
   parameter int SLOT_COUNT = rrts_pkg::SLOT_COUNT_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  rrts_pkg::dp_cmd_type          cmd,
   output rrts_pkg::dp_sts_type          sts,
   input  logic [rrts_pkg::ACTION_W-1:0] req_action,
   input  logic [rrts_pkg::SLOT_W-1:0]   req_task_slot,
   input  logic [rrts_pkg::PTR_W-1:0]    req_context_pointer,
   output logic [rrts_pkg::STATUS_W-1:0] rsp_status,
   output logic [rrts_pkg::SLOT_W-1:0]   rsp_chosen_slot,
   output logic [rrts_pkg::PTR_W-1:0]    rsp_resume_pointer,
   output logic [rrts_pkg::USE_W-1:0]    rsp_tasks_in_use,
   output logic [rrts_pkg::COUNT_W-1:0]  rsp_switch_total
);

   import rrts_pkg::*;

   localparam int SW = $clog2(SLOT_COUNT);
   localparam int HW = $clog2(SLOT_COUNT + 1);
   localparam int IW = ((SW > SLOT_W) ? SW : SLOT_W) + 1;

   // captured request
   action_type        action_ff;
   logic [SLOT_W-1:0] slot_ff;
   logic [PTR_W-1:0]  ptr_ff;

   // task table state
   logic [SLOT_COUNT-1:0] flags_ff, flags_in;
   logic                  cur_valid_ff, cur_valid_in;
   logic [SW-1:0]         cur_ff, cur_in;
   logic [HW-1:0]         hw_ff, hw_in;
   logic [COUNT_W-1:0]    cnt_ff, cnt_in;

   // per-item result
   status_type    res_status_ff, res_status_in;
   logic [SW-1:0] res_slot_ff, res_slot_in;
   logic          res_echo_ff, res_echo_in;
   logic          res_read_ff, res_read_in;

   // result register
   logic [STATUS_W-1:0] rsp_status_ff;
   logic [SLOT_W-1:0]   rsp_slot_ff;
   logic [PTR_W-1:0]    rsp_ptr_ff;
   logic [USE_W-1:0]    rsp_use_ff;
   logic [COUNT_W-1:0]  rsp_cnt_ff;

   // search results
   logic          free_found;
   logic [SW-1:0] free_idx;
   logic [SW-1:0] start_idx;
   logic          up_found, any_found;
   logic [SW-1:0] up_idx, any_idx;
   logic [IW-1:0] rm_wide;
   logic          rm_ok;

   // pointer store port
   logic             wr_en;
   logic [SW-1:0]    wr_addr;
   logic [PTR_W-1:0] rd_data;

   always_comb begin
      free_found = 1'b0;
      free_idx   = '0;
      for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
         if (!flags_ff[i]) begin
            free_found = 1'b1;
            free_idx   = SW'(i);
         end
      end
   end

   // round-robin: first running slot at or after start, else first running overall
   always_comb begin
      if (!cur_valid_ff || cur_ff == SW'(SLOT_COUNT - 1)) begin
         start_idx = '0;
      end else begin
         start_idx = cur_ff + SW'(1);
      end
   end

   always_comb begin
      up_found  = 1'b0;
      up_idx    = '0;
      any_found = 1'b0;
      any_idx   = '0;
      for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
         if (flags_ff[i]) begin
            any_found = 1'b1;
            any_idx   = SW'(i);
            if (SW'(i) >= start_idx) begin
               up_found = 1'b1;
               up_idx   = SW'(i);
            end
         end
      end
   end

   assign rm_wide = IW'(slot_ff);
   assign rm_ok   = (rm_wide != '0) && (rm_wide < IW'(SLOT_COUNT));

   always_comb begin
      flags_in      = flags_ff;
      cur_valid_in  = cur_valid_ff;
      cur_in        = cur_ff;
      hw_in         = hw_ff;
      cnt_in        = cnt_ff;
      res_status_in = res_status_ff;
      res_slot_in   = res_slot_ff;
      res_echo_in   = res_echo_ff;
      res_read_in   = res_read_ff;
      wr_en         = 1'b0;
      wr_addr       = free_idx;
      if (cmd.execute) begin
         res_status_in = STS_IGNORED;
         res_slot_in   = '0;
         res_echo_in   = 1'b0;
         res_read_in   = 1'b0;
         case (action_ff)
            ACT_ADD: begin
               if (free_found) begin
                  flags_in[free_idx] = 1'b1;
                  wr_en              = 1'b1;
                  wr_addr            = free_idx;
                  if (HW'(free_idx) >= hw_ff) begin
                     hw_in = HW'(free_idx) + HW'(1);
                  end
                  res_status_in = STS_DONE;
                  res_slot_in   = free_idx;
               end else begin
                  res_status_in = STS_FULL;
               end
            end
            ACT_REMOVE: begin
               if (rm_ok) begin
                  flags_in[rm_wide[SW-1:0]] = 1'b0;
                  res_status_in             = STS_DONE;
               end
            end
            ACT_SWITCH: begin
               cnt_in = cnt_ff + COUNT_W'(1);
               if (hw_ff == '0) begin
                  res_status_in = STS_NO_TASKS;
                  res_echo_in   = 1'b1;
               end else begin
                  // save outgoing pointer before the resume read
                  wr_en         = cur_valid_ff;
                  wr_addr       = cur_ff;
                  cur_valid_in  = 1'b1;
                  cur_in        = up_found ? up_idx : (any_found ? any_idx : '0);
                  res_status_in = STS_DONE;
                  res_slot_in   = cur_in;
                  res_read_in   = 1'b1;
               end
            end
            default: begin
               res_status_in = STS_IGNORED;
            end
         endcase
      end
   end

   assign sts.need_read = (action_ff == ACT_SWITCH) && (hw_ff != '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         flags_ff     <= '0;
         cur_valid_ff <= 1'b0;
         hw_ff        <= '0;
         cnt_ff       <= '0;
      end else begin
         flags_ff     <= flags_in;
         cur_valid_ff <= cur_valid_in;
         hw_ff        <= hw_in;
         cnt_ff       <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         action_ff <= action_type'(req_action);
         slot_ff   <= req_task_slot;
         ptr_ff    <= req_context_pointer;
      end
      cur_ff        <= cur_in;
      res_status_ff <= res_status_in;
      res_slot_ff   <= res_slot_in;
      res_echo_ff   <= res_echo_in;
      res_read_ff   <= res_read_in;
      if (cmd.load_rsp) begin
         rsp_status_ff <= res_status_ff;
         rsp_slot_ff   <= SLOT_W'(res_slot_ff);
         rsp_ptr_ff    <= res_read_ff ? rd_data : (res_echo_ff ? ptr_ff : '0);
         rsp_use_ff    <= USE_W'(hw_ff);
         rsp_cnt_ff    <= cnt_ff;
      end
   end

   rrts_ram #(
      .WIDTH (PTR_W),
      .DEPTH (SLOT_COUNT)
   ) u_ptr_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (ptr_ff),
      .rd_addr (res_slot_ff),
      .rd_data (rd_data)
   );

   assign rsp_status         = rsp_status_ff;
   assign rsp_chosen_slot    = rsp_slot_ff;
   assign rsp_resume_pointer = rsp_ptr_ff;
   assign rsp_tasks_in_use   = rsp_use_ff;
   assign rsp_switch_total   = rsp_cnt_ff;

`ifndef SYNTH
   a_hw_bound: assert property (@(posedge clock) disable iff (reset)
      hw_ff <= HW'(SLOT_COUNT))
      else $error("high-water count beyond table size");

   a_slot0_kept: assert property (@(posedge clock) disable iff (reset)
      hw_ff != '0 |-> flags_ff[0])
      else $error("slot 0 dead after table in use");

   a_cur_needs_use: assert property (@(posedge clock) disable iff (reset)
      cur_valid_ff |-> hw_ff != '0)
      else $error("slot selected on unused table");

   a_cnt_only_switch: assert property (@(posedge clock) disable iff (reset)
      !(cmd.execute && action_ff == ACT_SWITCH) |=> cnt_ff == $past(cnt_ff))
      else $error("switch counter moved without a switch");
`endif

endmodule

### rtl/round_robin_task_scheduler.sv
// Round-robin task table with one result beat for every request beat. Add claims the
// lowest dead slot and stores its initial context pointer; remove kills a slot (slot 0
// and slots past the table are refused); switch saves the outgoing pointer for the
// current slot, moves cyclically to the next running slot and returns its saved pointer.
// One request is worked at a time: the request beat is captured in the idle state and
// worked in the execute state; a switch on a table in use then passes the read state,
// the registered read of the pointer store after the outgoing pointer is written on its
// single write port; the result register is loaded in the finish state once it is free.
// A new request is taken the cycle after the result is loaded, so requests never
// overlap; the result register lets the next request in while a result still waits.
// Pointers of slots never added read as whatever the store holds.
module round_robin_task_scheduler #(
   parameter int SLOT_COUNT = rrts_pkg::SLOT_COUNT_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [rrts_pkg::ACTION_W-1:0] req_action,
   input  logic [rrts_pkg::SLOT_W-1:0]   req_task_slot,
   input  logic [rrts_pkg::PTR_W-1:0]    req_context_pointer,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [rrts_pkg::STATUS_W-1:0] rsp_status,
   output logic [rrts_pkg::SLOT_W-1:0]   rsp_chosen_slot,
   output logic [rrts_pkg::PTR_W-1:0]    rsp_resume_pointer,
   output logic [rrts_pkg::USE_W-1:0]    rsp_tasks_in_use,
   output logic [rrts_pkg::COUNT_W-1:0]  rsp_switch_total
);

   import rrts_pkg::*;

   dp_cmd_type cmd;
   dp_sts_type sts;

   rrts_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd),
      .sts       (sts)
   );

   rrts_dp #(
      .SLOT_COUNT (SLOT_COUNT)
   ) u_dp (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .sts                 (sts),
      .req_action          (req_action),
      .req_task_slot       (req_task_slot),
      .req_context_pointer (req_context_pointer),
      .rsp_status          (rsp_status),
      .rsp_chosen_slot     (rsp_chosen_slot),
      .rsp_resume_pointer  (rsp_resume_pointer),
      .rsp_tasks_in_use    (rsp_tasks_in_use),
      .rsp_switch_total    (rsp_switch_total)
   );

endmodule

### bench/tb_round_robin_task_scheduler.sv
`timescale 1ns / 1ps

module tb_round_robin_task_scheduler;
   import rrts_pkg::*;

   localparam int SLOTS = SLOT_COUNT_DEF;
   localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;
   localparam int NONE_ACTIVE = SLOTS;
   localparam int LONG_HOLD = 400;
   localparam int DRAIN_CYCLES = 20;

   typedef struct {
      status_type          status;
      logic [SLOT_W-1:0]   slot;
      logic [PTR_W-1:0]    resume;
      logic [USE_W-1:0]    in_use;
      logic [COUNT_W-1:0]  total;
   } sched_result_type;

   typedef enum {RX_OPEN, RX_CHOPPY, RX_SLOW} rx_mode_type;

   logic                clock;
   logic                reset;
   logic                req_valid;
   logic                req_ready;
   logic [ACTION_W-1:0] req_action;
   logic [SLOT_W-1:0]   req_task_slot;
   logic [PTR_W-1:0]    req_context_pointer;
   logic                rsp_valid;
   logic                rsp_ready;
   logic [STATUS_W-1:0] rsp_status;
   logic [SLOT_W-1:0]   rsp_chosen_slot;
   logic [PTR_W-1:0]    rsp_resume_pointer;
   logic [USE_W-1:0]    rsp_tasks_in_use;
   logic [COUNT_W-1:0]  rsp_switch_total;

   // scheduler shadow state
   bit                  slot_live [SLOTS];
   logic [PTR_W-1:0]    saved_ptr [SLOTS];
   int                  active_slot;
   int                  peak_slots;
   logic [COUNT_W-1:0]  switch_count;

   sched_result_type    pending_results[$];
   int                  fail_count;
   int                  burst_left;
   int                  gap_max;
   int                  hold_asks;
   int                  hold_served;

   round_robin_task_scheduler DUT (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_action          (req_action),
      .req_task_slot       (req_task_slot),
      .req_context_pointer (req_context_pointer),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_status          (rsp_status),
      .rsp_chosen_slot     (rsp_chosen_slot),
      .rsp_resume_pointer  (rsp_resume_pointer),
      .rsp_tasks_in_use    (rsp_tasks_in_use),
      .rsp_switch_total    (rsp_switch_total)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   initial begin
      #5_000_000;
      $display("TEST FAILED");
      $finish;
   end

   function automatic sched_result_type schedule_step(input logic [ACTION_W-1:0] act,
                                                      input logic [SLOT_W-1:0] slot,
                                                      input logic [PTR_W-1:0] ptr);
      sched_result_type r;
      int idx;
      int probe;
      bit found;
      r.status = STS_DONE;
      r.slot = '0;
      r.resume = '0;
      found = 1'b0;
      case (act)
         ACT_ADD: begin
            for (idx = 0; idx < SLOTS && !found; idx++) begin
               if (!slot_live[idx]) begin
                  found = 1'b1;
                  slot_live[idx] = 1'b1;
                  saved_ptr[idx] = ptr;
                  if (idx >= peak_slots) peak_slots = idx + 1;
                  r.slot = idx[SLOT_W-1:0];
               end
            end
            if (!found) r.status = STS_FULL;
         end
         ACT_REMOVE: begin
            // slot 0 can never be removed
            if (slot == 0 || slot >= SLOTS) r.status = STS_IGNORED;
            else slot_live[slot] = 1'b0;
         end
         ACT_SWITCH: begin
            switch_count++;
            if (peak_slots == 0) begin
               r.status = STS_NO_TASKS;
               r.resume = ptr;
            end else begin
               if (active_slot < SLOTS) saved_ptr[active_slot] = ptr;
               probe = active_slot;
               for (idx = 0; idx < SLOTS && !found; idx++) begin
                  probe = (probe >= SLOTS - 1) ? 0 : probe + 1;
                  if (slot_live[probe]) begin
                     found = 1'b1;
                     active_slot = probe;
                  end
               end
               if (!found) active_slot = 0;
               r.slot = active_slot[SLOT_W-1:0];
               r.resume = saved_ptr[active_slot];
            end
         end
         default: r.status = STS_IGNORED;
      endcase
      r.in_use = peak_slots[USE_W-1:0];
      r.total = switch_count;
      return r;
   endfunction

   task automatic send_item(input logic [ACTION_W-1:0] act, input logic [SLOT_W-1:0] slot,
                            input logic [PTR_W-1:0] ptr);
      req_valid <= 1'b1;
      req_action <= act;
      req_task_slot <= slot;
      req_context_pointer <= ptr;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      pending_results.push_back(schedule_step(act, slot, ptr));
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         burst_left = $urandom_range(0, 12);
         if (gap_max > 0) begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, gap_max)) @(posedge clock);
         end
      end
   endtask

   function automatic logic [PTR_W-1:0] random_ptr();
      return {$urandom, $urandom};
   endfunction

   task automatic check_field(input string what, input logic [63:0] want,
                              input logic [63:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin : rsp_check
      sched_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_results.size() == 0) begin
            $display("%0t: result beat with nothing expected, expected none, actual status %0d",
                     $time, rsp_status);
            fail_count++;
         end else begin
            want = pending_results.pop_front();
            check_field("status", 64'(want.status), 64'(rsp_status));
            check_field("chosen_slot", 64'(want.slot), 64'(rsp_chosen_slot));
            check_field("resume_pointer", want.resume, rsp_resume_pointer);
            check_field("tasks_in_use", 64'(want.in_use), 64'(rsp_tasks_in_use));
            check_field("switch_total", want.total, rsp_switch_total);
         end
      end
   end

   // receiver: random stall modes, plus a long hold when one is asked for
   initial begin : rsp_side
      int hold_left;
      int mode_left;
      rx_mode_type mode;
      hold_left = 0;
      mode_left = 0;
      mode = RX_OPEN;
      rsp_ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_served != hold_asks) begin
            hold_served = hold_asks;
            hold_left = LONG_HOLD;
         end
         if (mode_left == 0) begin
            mode = rx_mode_type'($urandom_range(0, 2));
            mode_left = $urandom_range(20, 80);
         end else begin
            mode_left--;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            case (mode)
               RX_OPEN:   rsp_ready <= 1'b1;
               RX_CHOPPY: rsp_ready <= 1'($urandom_range(0, 1));
               default:   rsp_ready <= ($urandom_range(0, 3) == 0);
            endcase
         end
      end
   end

   task automatic test_empty_table();
      gap_max = 3;
      // switch before any add echoes the pointer
      send_item(ACT_SWITCH, 4'hF, '1);
      send_item(ACT_SWITCH, 4'h0, '0);
      send_item(ACT_UNUSED, 4'h3, random_ptr());
      send_item(ACT_REMOVE, 4'h0, random_ptr());
      // dead slot remove is still accepted
      send_item(ACT_REMOVE, 4'hF, '1);
   endtask

   task automatic test_fill_table();
      int n;
      logic [PTR_W-1:0] p;
      gap_max = 0;
      for (n = 0; n < SLOTS; n++) begin
         case (n)
            0:         p = '0;
            1:         p = {32{2'b10}};
            2:         p = {32{2'b01}};
            SLOTS - 1: p = '1;
            default:   p = random_ptr();
         endcase
         send_item(ACT_ADD, 4'hF, p);
      end
      send_item(ACT_ADD, 4'h0, random_ptr());
   endtask

   task automatic test_first_switch();
      gap_max = 2;
      // nothing selected yet, search starts at slot 0
      send_item(ACT_SWITCH, 4'h5, random_ptr());
      send_item(ACT_SWITCH, 4'hA, '1);
   endtask

   task automatic test_random_traffic(input int count);
      int n;
      int pick;
      int add_cut;
      int rem_cut;
      int sw_cut;
      add_cut = 35;
      rem_cut = 65;
      sw_cut = 95;
      for (n = 0; n < count; n++) begin
         if (n % 100 == 0) begin
            gap_max = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
            case ($urandom_range(0, 2))
               0: begin add_cut = 50; rem_cut = 70; end
               1: begin add_cut = 20; rem_cut = 70; end
               default: begin add_cut = 20; rem_cut = 40; end
            endcase
         end
         pick = $urandom_range(0, 99);
         if (pick < add_cut)
            send_item(ACT_ADD, SLOT_W'($urandom_range(0, 15)), random_ptr());
         else if (pick < rem_cut)
            send_item(ACT_REMOVE, SLOT_W'($urandom_range(0, 15)), random_ptr());
         else if (pick < sw_cut)
            send_item(ACT_SWITCH, SLOT_W'($urandom_range(0, 15)), random_ptr());
         else
            send_item(ACT_UNUSED, SLOT_W'($urandom_range(0, 15)), random_ptr());
      end
   endtask

   task automatic test_backpressure();
      int n;
      gap_max = 0;
      hold_asks++;
      // keep offering beats while the receiver holds off
      for (n = 0; n < 60; n++) begin
         case ($urandom_range(0, 2))
            0: send_item(ACT_ADD, SLOT_W'($urandom_range(0, 15)), random_ptr());
            1: send_item(ACT_REMOVE, SLOT_W'($urandom_range(0, 15)), random_ptr());
            default: send_item(ACT_SWITCH, SLOT_W'($urandom_range(0, 15)), random_ptr());
         endcase
      end
   endtask

   initial begin
      int idx;
      for (idx = 0; idx < SLOTS; idx++) begin
         slot_live[idx] = 1'b0;
         saved_ptr[idx] = '0;
      end
      active_slot = NONE_ACTIVE;
      peak_slots = 0;
      switch_count = '0;
      fail_count = 0;
      burst_left = 0;
      gap_max = 0;
      hold_asks = 0;
      hold_served = 0;
      req_valid <= 1'b0;
      req_action <= ACT_ADD;
      req_task_slot <= '0;
      req_context_pointer <= '0;
      reset <= 1'b1;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_empty_table();
      test_fill_table();
      test_first_switch();
      test_random_traffic(700);
      test_backpressure();
      test_random_traffic(700);
      req_valid <= 1'b0;

      while (pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule

### filelist.f
rtl/rrts_pkg.sv
rtl/rrts_ram.sv
rtl/rrts_ctrl.sv
rtl/rrts_dp.sv
rtl/round_robin_task_scheduler.sv
bench/tb_round_robin_task_scheduler.sv
